/* rtl/slefp_pkg.sv */
// Shared types and constants for the start/length/end frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slefp_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 9;
  localparam int EV_W        = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_PAYLOAD = 256;

  // padded widths of the stream buses
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h01;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h04;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE = 1'b0,
    REG_END_BYTE   = 1'b1
  } reg_idx_t;

  typedef enum logic [EV_W-1:0] {
    EV_HEADER   = 3'd0,
    EV_DROP     = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_COMPLETE = 3'd3,
    EV_EMPTY    = 3'd4,
    EV_BADEND   = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_RES0 = 6'b000010,
    PH_RES1 = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_END  = 6'b100000
  } phase_t;

  typedef struct packed {
    event_t              event_res;
    logic [BYTE_W-1:0]   payload_byte;
    logic [LEN_W-1:0]    frame_length;
  } result_t;

endpackage

/* rtl/start_length_end_frame_parser_unit.sv */
// Top level of the start/length/end frame parser.
// Instantiates slefp_core and slefp_out_reg; depends on slefp_pkg.
//
// Usage:
//   in_*  : one received byte per word in in_tdata[7:0].
//   out_* : one result word per input word. out_tuser[2:0] holds the event
//           code, out_tdata[7:0] the payload byte (zero unless a payload
//           event), out_tdata[16:8] the payload count of the frame.
//   cfg_* : cfg_we writes cfg_wdata into the start byte (index 0) or end
//           byte (index 1) register; write only while the block is idle.
// Each result is registered: a word that is taken shows its result in the cycle after.
// Throughput is one word per cycle while results are taken, set by the single result
// register, which refills in the cycle it is drained.
// Reset (rst_n low, synchronous) puts the parser back to hunting for a
// start byte, restores start byte 0x01 and end byte 0x04, and empties the
// result register.
// When the receiver holds out_tready low with a result pending, in_tready
// drops and the parser state stays frozen until the result is taken.
`timescale 1ns / 1ps

module start_length_end_frame_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [slefp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [slefp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] payload_byte, [16:8] frame_length
  output logic [slefp_pkg::EV_W-1:0]          out_tuser,  // [2:0] event_res
  input  logic                                cfg_we,
  input  logic [slefp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [slefp_pkg::BYTE_W-1:0]        cfg_wdata
);
  import slefp_pkg::*;

  logic    in_fire;
  result_t core_res;
  result_t out_res;

  assign in_fire = in_tvalid && in_tready;

  slefp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .rx_byte   (in_tdata[BYTE_W-1:0]),
    .res       (core_res)
  );

  slefp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_res   (core_res),
    .load_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tuser = out_res.event_res;
  assign out_tdata = {(OUT_TDATA_W - BYTE_W - LEN_W)'(0),
                      out_res.frame_length, out_res.payload_byte};

endmodule

/* rtl/slefp_core.sv */
// Frame parser state machine: config registers, phase, byte and payload counters.
// Produces one result per accepted word. Depends on slefp_pkg.
`timescale 1ns / 1ps

module slefp_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [slefp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [slefp_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                              in_fire,
  input  logic [slefp_pkg::BYTE_W-1:0]      rx_byte,
  output slefp_pkg::result_t                res
);
  import slefp_pkg::*;

  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] end_byte_r;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  count_inc;
  logic [BYTE_W-1:0] left_dec;

  assign count_inc = count_r + LEN_W'(1);
  assign left_dec  = bytes_left_r - BYTE_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    count_nxt        = count_r;
    res.event_res    = EV_HEADER;
    res.payload_byte = '0;
    res.frame_length = count_r;
    unique case (phase_r)
      PH_RES0: phase_nxt = PH_RES1;
      PH_RES1: phase_nxt = PH_LEN;
      PH_LEN: begin
        bytes_left_nxt = rx_byte;
        phase_nxt      = (rx_byte != '0) ? PH_DATA : PH_END;
      end
      PH_DATA: begin
        res.frame_length = count_inc;
        if (count_inc >= LEN_W'(MAX_PAYLOAD)) begin
          // limit reached: abort the frame on this word
          res.event_res  = EV_OVERFLOW;
          phase_nxt      = PH_HUNT;
          bytes_left_nxt = '0;
          count_nxt      = '0;
        end else begin
          res.event_res    = EV_PAYLOAD;
          res.payload_byte = rx_byte;
          count_nxt        = count_inc;
          bytes_left_nxt   = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_END;
          end
        end
      end
      PH_END: begin
        if (rx_byte == end_byte_r) begin
          res.event_res = (count_r != '0) ? EV_COMPLETE : EV_EMPTY;
        end else begin
          res.event_res = EV_BADEND;
        end
        phase_nxt      = PH_HUNT;
        bytes_left_nxt = '0;
        count_nxt      = '0;
      end
      default: begin
        res.frame_length = '0;
        if (rx_byte == start_byte_r) begin
          res.event_res = EV_HEADER;
          phase_nxt     = PH_RES0;
        end else begin
          res.event_res = EV_DROP;
          phase_nxt     = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_BYTE: start_byte_r <= cfg_wdata;
        REG_END_BYTE:   end_byte_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      bytes_left_r <= '0;
      count_r      <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

/* rtl/slefp_out_reg.sv */
// Result register between the parser and the output stream.
// Loads whenever empty or being drained. Depends on slefp_pkg.
`timescale 1ns / 1ps

module slefp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  input  slefp_pkg::result_t load_res,
  output logic               load_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output slefp_pkg::result_t out_res
);
  import slefp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

/* rtl/slefp_checker.sv */
// Port-level checks for start_length_end_frame_parser_unit, attached by bind.
// Depends on slefp_pkg.
`timescale 1ns / 1ps

module slefp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [slefp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [slefp_pkg::EV_W-1:0]          out_tuser
);
  import slefp_pkg::*;

  // every accepted word has its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("no result after accepted word");

  // payload byte field is zero unless a payload event
  a_pb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != EV_PAYLOAD) |-> (out_tdata[7:0] == '0))
    else $error("payload byte set on non-payload event");

  // dropped words carry no frame count
  a_drop_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EV_DROP) |-> (out_tdata[16:8] == '0))
    else $error("frame length set while hunting");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind start_length_end_frame_parser_unit slefp_checker u_slefp_checker (.*);

/* sim/tb_start_length_end_frame_parser_unit.sv */
// Self-checking bench for start_length_end_frame_parser_unit: byte streams with
// random and legal frames are checked word by word against an in-bench parser.
// Depends on slefp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_start_length_end_frame_parser_unit;
  import slefp_pkg::*;

  localparam int SEG_ITEMS   = 275;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    bit                pinned;
    result_t           res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [EV_W-1:0]        out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [BYTE_W-1:0]      cfg_wdata;

  // parser mirror
  phase_t            ph;
  logic [BYTE_W-1:0] left_cnt;
  logic [LEN_W-1:0]  pay_cnt;
  logic [BYTE_W-1:0] sof_byte;
  logic [BYTE_W-1:0] eof_byte;

  result_t   pending_res[$];
  result_t   got_res;
  result_t   want_res;
  bit        pin_use;
  result_t   pin_res;
  stim_row_t dir_rows[25];
  int        sent_cnt;
  int        fail_cnt;
  int        quiet_cycles;
  int        src_idle_pct;
  int        sink_idle_pct;

  start_length_end_frame_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t row(logic [BYTE_W-1:0] rx, bit pinned, event_t ev,
                                    logic [BYTE_W-1:0] pb, logic [LEN_W-1:0] len);
    stim_row_t r;
    r.rx                 = rx;
    r.pinned             = pinned;
    r.res.event_res      = ev;
    r.res.payload_byte   = pb;
    r.res.frame_length   = len;
    return r;
  endfunction

  function automatic void clear_parser();
    ph       = PH_HUNT;
    left_cnt = '0;
    pay_cnt  = '0;
  endfunction

  // advances the mirrored parser by one byte and returns the word it gives
  function automatic result_t parse_byte(logic [BYTE_W-1:0] b);
    result_t r;
    r.event_res    = EV_HEADER;
    r.payload_byte = '0;
    r.frame_length = '0;
    case (ph)
      PH_RES0: begin
        ph             = PH_RES1;
        r.frame_length = pay_cnt;
      end
      PH_RES1: begin
        ph             = PH_LEN;
        r.frame_length = pay_cnt;
      end
      PH_LEN: begin
        left_cnt       = b;
        ph             = (b != '0) ? PH_DATA : PH_END;
        r.frame_length = pay_cnt;
      end
      PH_DATA: begin
        pay_cnt  = pay_cnt + 1'b1;
        left_cnt = left_cnt - 1'b1;
        if (left_cnt == '0) ph = PH_END;
        r.frame_length = pay_cnt;
        if (pay_cnt >= MAX_PAYLOAD) begin
          r.event_res = EV_OVERFLOW;
          clear_parser();
        end else begin
          r.event_res    = EV_PAYLOAD;
          r.payload_byte = b;
        end
      end
      PH_END: begin
        r.frame_length = pay_cnt;
        if (b == eof_byte) r.event_res = (pay_cnt != '0) ? EV_COMPLETE : EV_EMPTY;
        else r.event_res = EV_BADEND;
        clear_parser();
      end
      default: begin
        if (b == sof_byte) begin
          ph          = PH_RES0;
          r.event_res = EV_HEADER;
        end else begin
          ph          = PH_HUNT;
          r.event_res = EV_DROP;
        end
      end
    endcase
    return r;
  endfunction

  // result side: compare against the oldest expectation, then log new input words
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (pending_res.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10)
            $display("unexpected result word ev=%0d data=%0h", out_tuser, out_tdata);
        end else begin
          want_res = pending_res.pop_front();
          if (out_tuser !== want_res.event_res || out_tdata[7:0] !== want_res.payload_byte ||
              out_tdata[16:8] !== want_res.frame_length) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10)
              $display("mismatch: got ev=%0d pb=%0h len=%0d, want ev=%0d pb=%0h len=%0d",
                       out_tuser, out_tdata[7:0], out_tdata[16:8], want_res.event_res,
                       want_res.payload_byte, want_res.frame_length);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got_res = parse_byte(in_tdata);
        pending_res.push_back(pin_use ? pin_res : got_res);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic push_byte(logic [BYTE_W-1:0] b, bit pinned = 1'b0, result_t pin = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    pin_use   = pinned;
    pin_res   = pin;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_BYTE: sof_byte = v;
      REG_END_BYTE:   eof_byte = v;
      default: ;
    endcase
  endtask

  // mostly legal frames, some with a wrong end byte, some plain line noise;
  // a length of 255 is the longest frame, so overflow cannot occur at 256
  task automatic send_frame(int force_len);
    int pick;
    int len;
    logic [BYTE_W-1:0] eb;
    pick = $urandom_range(99);
    if (pick >= 88) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    end else begin
      len = $urandom_range(99);
      len = (len < 3) ? 255 : (len < 12) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (force_len >= 0) len = force_len;
      push_byte(sof_byte);
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(8'(len));
      repeat (len) push_byte(8'($urandom));
      eb = (pick >= 72) ? 8'($urandom) : eof_byte;
      push_byte(eb);
    end
  endtask

  initial begin
    int seg_start;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    pin_use       = 1'b0;
    pin_res       = '0;
    sent_cnt      = 0;
    fail_cnt      = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 6;
    sink_idle_pct = 80;
    sof_byte      = START_BYTE_RST;
    eof_byte      = END_BYTE_RST;
    clear_parser();

    // defaults: start 01, end 04
    dir_rows[0]  = row(8'h00, 1, EV_DROP,     8'h00, 9'd0);
    dir_rows[1]  = row(8'hff, 1, EV_DROP,     8'h00, 9'd0);
    dir_rows[2]  = row(8'h01, 1, EV_HEADER,   8'h00, 9'd0);
    dir_rows[3]  = row(8'hff, 1, EV_HEADER,   8'h00, 9'd0);
    dir_rows[4]  = row(8'h00, 1, EV_HEADER,   8'h00, 9'd0);
    dir_rows[5]  = row(8'h00, 1, EV_HEADER,   8'h00, 9'd0);  // zero length
    dir_rows[6]  = row(8'h04, 1, EV_EMPTY,    8'h00, 9'd0);
    dir_rows[7]  = row(8'h01, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[8]  = row(8'haa, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[9]  = row(8'h55, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[10] = row(8'h02, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[11] = row(8'hff, 1, EV_PAYLOAD,  8'hff, 9'd1);
    dir_rows[12] = row(8'h00, 1, EV_PAYLOAD,  8'h00, 9'd2);
    dir_rows[13] = row(8'h04, 1, EV_COMPLETE, 8'h00, 9'd2);
    dir_rows[14] = row(8'h01, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[15] = row(8'h00, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[16] = row(8'h00, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[17] = row(8'h01, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[18] = row(8'h7e, 0, EV_HEADER,   8'h00, 9'd0);
    // wrong end byte that equals the start byte must not open a frame
    dir_rows[19] = row(8'h01, 1, EV_BADEND,   8'h00, 9'd1);
    dir_rows[20] = row(8'h02, 1, EV_DROP,     8'h00, 9'd0);
    dir_rows[21] = row(8'h01, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[22] = row(8'h11, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[23] = row(8'h22, 0, EV_HEADER,   8'h00, 9'd0);
    dir_rows[24] = row(8'h00, 0, EV_HEADER,   8'h00, 9'd0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_byte(dir_rows[i].rx, dir_rows[i].pinned, dir_rows[i].res);
    // empty frame left waiting for its end byte, closed with a bad one
    push_byte(8'h05);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg / 2)
        0: begin
          src_idle_pct  = 6;
          sink_idle_pct = 80;
        end
        1: begin
          src_idle_pct  = 80;
          sink_idle_pct = 6;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          write_reg(REG_START_BYTE, START_BYTE_RST);
          write_reg(REG_END_BYTE, END_BYTE_RST);
        end
        1: begin
          write_reg(REG_START_BYTE, 8'h00);
          write_reg(REG_END_BYTE, 8'hff);
        end
        2: begin
          write_reg(REG_START_BYTE, 8'hff);
          write_reg(REG_END_BYTE, 8'h00);
        end
        4: begin
          // start and end marker share one value
          write_reg(REG_START_BYTE, 8'($urandom));
          write_reg(REG_END_BYTE, sof_byte);
        end
        default: begin
          write_reg(REG_START_BYTE, 8'($urandom));
          write_reg(REG_END_BYTE, 8'($urandom));
        end
      endcase
      seg_start = sent_cnt;
      if (seg == 2 || seg == 5) send_frame(255);
      while (sent_cnt - seg_start < SEG_ITEMS) send_frame(-1);
    end

    settle();
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
